### hdl/nv21rgb_pkg.sv
// shared types, constants and helpers for the nv21 to rgb888 converter
package nv21rgb_pkg;

    // largest frame the luma memory holds
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // field and register widths
    localparam int SIZE_W  = 11;
    localparam int COORD_W = 10;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 21;
    localparam int K_W     = POS_W - 1;
    localparam int CNT_W   = $clog2(K_W);
    localparam int LEN_W   = 2 * SIZE_W;
    localparam int TOT_W   = LEN_W + 1;
    localparam int CC_W    = $clog2(MAX_WIDTH) - 1;
    localparam int CR_W    = $clog2(MAX_HEIGHT) - 1;

    // apb side
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_FRAME_WIDTH  = 2'd0;
    localparam t_reg_idx REG_FRAME_HEIGHT = 2'd1;
    localparam t_reg_idx REG_ROTATE_MODE  = 2'd2;

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(480);

    // color conversion
    localparam int Y1_W      = 19;
    localparam int MUL_W     = 20;
    localparam int SUM_W     = 22;
    localparam int OUT_LSB   = 10;
    localparam int COEF_Y    = 1192;
    localparam int COEF_RV   = 1634;
    localparam int COEF_GV   = 833;
    localparam int COEF_GU   = 400;
    localparam int COEF_BU   = 2066;
    localparam int CLAMP_MAX = 262143;
    localparam logic [BYTE_W-1:0] Y_MIN      = 8'd16;
    localparam logic [BYTE_W:0]   CHROMA_MID = 9'd128;

    typedef logic [SIZE_W-1:0] t_size;

    typedef logic [1:0] t_sub;
    localparam t_sub SUB_LAST = 2'd3;

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_LOAD = 3'b010,
        DIV_RUN  = 3'b100
    } t_div_state;

    // per-pixel control carried down the color pipeline
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
        logic               fend;
        logic [BYTE_W-1:0]  v;
        logic [BYTE_W-1:0]  u;
    } t_pix_meta;

    // even size limited to 2..max
    function automatic t_size eff_size(input t_size size_reg, input int unsigned maxv);
        t_size       v;
        int unsigned m;
        m = maxv & ~32'd1;
        v = {size_reg[SIZE_W-1:1], 1'b0};
        if (v < SIZE_W'(2)) v = SIZE_W'(2);
        if (32'(v) > m) v = SIZE_W'(m);
        return v;
    endfunction

    // clamp to 0..262143 and take bits 17..10
    function automatic logic [BYTE_W-1:0] clamp_comp(input logic signed [SUM_W-1:0] t);
        logic [BYTE_W-1:0] res;
        if (t < 0) res = '0;
        else if (t > SUM_W'(CLAMP_MAX)) res = '1;
        else res = t[OUT_LSB+BYTE_W-1:OUT_LSB];
        return res;
    endfunction

endpackage

### hdl/nv21rgb_ram.sv
// generic simple dual-port ram with registered read
module nv21rgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/nv21_to_rgb888_rotate.sv
// nv21 byte stream to rgb888 pixels with optional 90 degree rotation
// first pixel of a pair: u byte, job register, read, product and output stages; the other three follow
// luma and v bytes 1 per cycle unless stalled; a u byte waits for the prior pair's reads, one per pixel
// first luma byte of a new frame waits for the last pair's reads to finish
// a width or height write stalls input while the chroma position is recomputed
// reset: synchronous, active low; clears control and config, luma memory keeps its content
module nv21_to_rgb888_rotate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // byte input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [nv21rgb_pkg::BYTE_W-1:0]     i_frame_byte,
    // pixel output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [nv21rgb_pkg::BYTE_W-1:0]     o_red,
    output logic [nv21rgb_pkg::BYTE_W-1:0]     o_green,
    output logic [nv21rgb_pkg::BYTE_W-1:0]     o_blue,
    output logic [nv21rgb_pkg::COORD_W-1:0]    o_out_col,
    output logic [nv21rgb_pkg::COORD_W-1:0]    o_out_row,
    output logic                               o_last_of_run,
    output logic                               o_frame_end,
    // apb configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nv21rgb_pkg::PADDR_W-1:0]    paddr,
    input  logic [nv21rgb_pkg::PDATA_W-1:0]    pwdata,
    output logic [nv21rgb_pkg::PDATA_W-1:0]    prdata,
    output logic                               pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                         r_rotate_mode;
    nv21rgb_pkg::t_size           r_frame_width;
    nv21rgb_pkg::t_size           r_frame_height;
    logic                         cfg_wr;
    nv21rgb_pkg::t_reg_idx        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[nv21rgb_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= nv21rgb_pkg::RST_FRAME_WIDTH;
            r_frame_height <= nv21rgb_pkg::RST_FRAME_HEIGHT;
            r_rotate_mode  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                nv21rgb_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[nv21rgb_pkg::SIZE_W-1:0];
                end
                nv21rgb_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[nv21rgb_pkg::SIZE_W-1:0];
                end
                nv21rgb_pkg::REG_ROTATE_MODE: begin
                    r_rotate_mode <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            nv21rgb_pkg::REG_FRAME_WIDTH:  prdata = nv21rgb_pkg::PDATA_W'(r_frame_width);
            nv21rgb_pkg::REG_FRAME_HEIGHT: prdata = nv21rgb_pkg::PDATA_W'(r_frame_height);
            nv21rgb_pkg::REG_ROTATE_MODE:  prdata = nv21rgb_pkg::PDATA_W'(r_rotate_mode);
            default:                       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // frame geometry, derived from the size registers every cycle
    // ------------------------------------------------------------------
    nv21rgb_pkg::t_size                 w_eff;
    nv21rgb_pkg::t_size                 h_eff;
    logic [nv21rgb_pkg::LEN_W-1:0]      luma_len;
    logic [nv21rgb_pkg::TOT_W-1:0]      total;
    logic [nv21rgb_pkg::CC_W:0]         half;

    assign w_eff    = nv21rgb_pkg::eff_size(r_frame_width, nv21rgb_pkg::MAX_WIDTH);
    assign h_eff    = nv21rgb_pkg::eff_size(r_frame_height, nv21rgb_pkg::MAX_HEIGHT);
    assign luma_len = nv21rgb_pkg::LEN_W'(w_eff) * nv21rgb_pkg::LEN_W'(h_eff);
    assign total    = nv21rgb_pkg::TOT_W'(luma_len) + nv21rgb_pkg::TOT_W'(luma_len >> 1);
    // chroma pairs per row
    assign half     = (nv21rgb_pkg::CC_W + 1)'(w_eff >> 1);

    // ------------------------------------------------------------------
    // byte position and classification of the next request
    // ------------------------------------------------------------------
    logic [nv21rgb_pkg::POS_W-1:0]      r_pos;
    logic [nv21rgb_pkg::BYTE_W-1:0]     r_held_v;
    logic [nv21rgb_pkg::CC_W-1:0]       r_cc;      // chroma column of the next pair
    logic [nv21rgb_pkg::CR_W-1:0]       r_cr;      // chroma row of the next pair

    logic [nv21rgb_pkg::POS_W-1:0]      pos_cur;
    logic [nv21rgb_pkg::POS_W-1:0]      pos_inc;
    logic [nv21rgb_pkg::POS_W-1:0]      chroma_off;
    logic                               is_luma;
    logic                               is_v;
    logic                               is_u;
    logic                               pair_fend;
    logic                               cc_wrap;
    logic                               accept;

    // a position at or past the frame length starts a new frame
    assign pos_cur = (nv21rgb_pkg::TOT_W'(r_pos) >= total) ? '0 : r_pos;
    assign pos_inc = pos_cur + nv21rgb_pkg::POS_W'(1);
    assign is_luma = nv21rgb_pkg::TOT_W'(pos_cur) < nv21rgb_pkg::TOT_W'(luma_len);
    assign chroma_off = nv21rgb_pkg::POS_W'(nv21rgb_pkg::TOT_W'(pos_cur)
                                            - nv21rgb_pkg::TOT_W'(luma_len));
    // chroma bytes alternate v then u
    assign is_v      = !is_luma & !chroma_off[0];
    assign is_u      = !is_luma & chroma_off[0];
    assign pair_fend = nv21rgb_pkg::TOT_W'(pos_inc) == total;
    assign cc_wrap   = (nv21rgb_pkg::CC_W + 1)'(r_cc) == (half - (nv21rgb_pkg::CC_W + 1)'(1));

    // ------------------------------------------------------------------
    // chroma position recompute after a size change: restoring divide of the
    // pair index by the pairs per row, one quotient bit per cycle
    // ------------------------------------------------------------------
    nv21rgb_pkg::t_div_state            r_div_state;
    logic [nv21rgb_pkg::CNT_W-1:0]      r_div_cnt;
    logic [nv21rgb_pkg::K_W-1:0]        r_div_num;
    logic [nv21rgb_pkg::CC_W-1:0]       r_div_rem;
    logic [nv21rgb_pkg::CC_W:0]         div_trial;
    logic                               div_ge;
    logic [nv21rgb_pkg::CC_W-1:0]       n_div_rem;
    logic [nv21rgb_pkg::K_W-1:0]        n_div_num;
    logic                               div_done;
    logic                               size_wr;

    assign size_wr   = cfg_wr & ((cfg_idx == nv21rgb_pkg::REG_FRAME_WIDTH) ||
                                 (cfg_idx == nv21rgb_pkg::REG_FRAME_HEIGHT));
    assign div_trial = {r_div_rem, r_div_num[nv21rgb_pkg::K_W-1]};
    assign div_ge    = div_trial >= half;
    assign n_div_rem = div_ge ? nv21rgb_pkg::CC_W'(div_trial - half)
                              : nv21rgb_pkg::CC_W'(div_trial);
    assign n_div_num = {r_div_num[nv21rgb_pkg::K_W-2:0], div_ge};
    assign div_done  = (r_div_state == nv21rgb_pkg::DIV_RUN) &&
                       (r_div_cnt == nv21rgb_pkg::CNT_W'(nv21rgb_pkg::K_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_state <= nv21rgb_pkg::DIV_IDLE;
        end else if (size_wr) begin
            r_div_state <= nv21rgb_pkg::DIV_LOAD;
        end else begin
            unique case (r_div_state)
                nv21rgb_pkg::DIV_IDLE: begin
                end
                nv21rgb_pkg::DIV_LOAD: begin
                    r_div_state <= nv21rgb_pkg::DIV_RUN;
                end
                nv21rgb_pkg::DIV_RUN: begin
                    if (div_done) begin
                        r_div_state <= nv21rgb_pkg::DIV_IDLE;
                    end
                end
                default: begin
                    r_div_state <= nv21rgb_pkg::DIV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_state == nv21rgb_pkg::DIV_LOAD) begin
            r_div_num <= chroma_off[nv21rgb_pkg::POS_W-1:1];
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (r_div_state == nv21rgb_pkg::DIV_RUN) begin
            r_div_num <= n_div_num;
            r_div_rem <= n_div_rem;
            r_div_cnt <= r_div_cnt + nv21rgb_pkg::CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // pair job: unless the output stalls, one u byte becomes four luma reads, one per cycle
    // ------------------------------------------------------------------
    logic                               r_job_valid;
    nv21rgb_pkg::t_sub                  r_job_sub;
    logic [nv21rgb_pkg::CC_W-1:0]       r_job_cc;
    logic [nv21rgb_pkg::CR_W-1:0]       r_job_cr;
    logic [nv21rgb_pkg::BYTE_W-1:0]     r_job_v;
    logic [nv21rgb_pkg::BYTE_W-1:0]     r_job_u;
    logic                               r_job_fend;
    logic                               adv;
    logic                               job_issue;
    logic                               job_last_issue;

    // whole color pipeline moves together, held only by a stalled output
    assign adv            = !o_valid | !i_stall;
    assign job_issue      = r_job_valid & adv;
    assign job_last_issue = job_issue & (r_job_sub == nv21rgb_pkg::SUB_LAST);

    // hold off every byte during a position recompute, a u byte until the slot frees, and luma until the last
    // pair's reads are done so a new frame never overwrites them
    assign o_stall = (r_div_state != nv21rgb_pkg::DIV_IDLE)
                   | (r_job_valid & is_luma)
                   | (r_job_valid & is_u & !job_last_issue);
    assign accept  = i_valid & !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_held_v <= '0;
            r_cc     <= '0;
            r_cr     <= '0;
        end else if (accept) begin
            if (is_luma) begin
                r_pos <= pos_inc;
                r_cc  <= '0;
                r_cr  <= '0;
            end else if (is_v) begin
                r_held_v <= i_frame_byte;
                r_pos    <= pos_inc;
            end else begin
                r_pos <= pair_fend ? '0 : pos_inc;
                if (cc_wrap) begin
                    r_cc <= '0;
                    r_cr <= r_cr + nv21rgb_pkg::CR_W'(1);
                end else begin
                    r_cc <= r_cc + nv21rgb_pkg::CC_W'(1);
                end
            end
        end else if (div_done) begin
            r_cc <= n_div_rem;
            r_cr <= nv21rgb_pkg::CR_W'(n_div_num);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_job_sub   <= '0;
        end else if (accept & is_u) begin
            r_job_valid <= 1'b1;
            r_job_sub   <= '0;
        end else if (job_issue) begin
            r_job_sub <= r_job_sub + nv21rgb_pkg::t_sub'(1);
            if (r_job_sub == nv21rgb_pkg::SUB_LAST) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept & is_u) begin
            r_job_cc   <= r_cc;
            r_job_cr   <= r_cr;
            r_job_v    <= r_held_v;
            r_job_u    <= i_frame_byte;
            r_job_fend <= pair_fend;
        end
    end

    // pixel order in a pair: top-left, top-right, bottom-left, bottom-right
    logic [nv21rgb_pkg::CC_W:0]         pix_i;
    logic [nv21rgb_pkg::CR_W:0]         pix_j;
    logic [nv21rgb_pkg::LEN_W-1:0]      row_base;
    logic [nv21rgb_pkg::ADDR_W-1:0]     rd_addr;
    logic [nv21rgb_pkg::SIZE_W-1:0]     rot_col;
    nv21rgb_pkg::t_pix_meta             job_meta;

    assign pix_i    = {r_job_cc, r_job_sub[0]};
    assign pix_j    = {r_job_cr, r_job_sub[1]};
    assign row_base = nv21rgb_pkg::LEN_W'(pix_j) * nv21rgb_pkg::LEN_W'(w_eff);
    assign rd_addr  = nv21rgb_pkg::ADDR_W'(row_base + nv21rgb_pkg::LEN_W'(pix_i));
    assign rot_col  = h_eff - nv21rgb_pkg::SIZE_W'(1) - nv21rgb_pkg::SIZE_W'(pix_j);

    always_comb begin
        job_meta.col  = r_rotate_mode ? nv21rgb_pkg::COORD_W'(rot_col)
                                      : nv21rgb_pkg::COORD_W'(pix_i);
        job_meta.row  = r_rotate_mode ? nv21rgb_pkg::COORD_W'(pix_i)
                                      : nv21rgb_pkg::COORD_W'(pix_j);
        job_meta.last = r_job_sub == nv21rgb_pkg::SUB_LAST;
        job_meta.fend = r_job_fend & (r_job_sub == nv21rgb_pkg::SUB_LAST);
        job_meta.v    = r_job_v;
        job_meta.u    = r_job_u;
    end

    // ------------------------------------------------------------------
    // luma memory: written by luma bytes, read by pair jobs
    // ------------------------------------------------------------------
    logic                               ram_we;
    logic [nv21rgb_pkg::BYTE_W-1:0]     ram_rdata;

    assign ram_we = accept & is_luma;

    nv21rgb_ram #(
        .WIDTH (nv21rgb_pkg::BYTE_W),
        .DEPTH (nv21rgb_pkg::STORE_DEPTH)
    ) u_luma_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (nv21rgb_pkg::ADDR_W'(pos_cur)),
        .i_wdata (i_frame_byte),
        .i_re    (job_issue),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // color pipeline: read stage, product stage, sum and clamp into output
    // ------------------------------------------------------------------
    logic                                   r_rd_valid;
    nv21rgb_pkg::t_pix_meta                 r_rd_meta;
    logic                                   r_mul_valid;
    nv21rgb_pkg::t_pix_meta                 r_mul_meta;
    logic [nv21rgb_pkg::Y1_W-1:0]           r_mul_y1;
    logic signed [nv21rgb_pkg::MUL_W-1:0]   r_mul_pr;
    logic signed [nv21rgb_pkg::MUL_W-1:0]   r_mul_pgv;
    logic signed [nv21rgb_pkg::MUL_W-1:0]   r_mul_pgu;
    logic signed [nv21rgb_pkg::MUL_W-1:0]   r_mul_pb;
    logic                                   r_out_valid;
    logic [nv21rgb_pkg::BYTE_W-1:0]         r_out_red;
    logic [nv21rgb_pkg::BYTE_W-1:0]         r_out_green;
    logic [nv21rgb_pkg::BYTE_W-1:0]         r_out_blue;
    logic [nv21rgb_pkg::COORD_W-1:0]        r_out_col;
    logic [nv21rgb_pkg::COORD_W-1:0]        r_out_row;
    logic                                   r_out_last;
    logic                                   r_out_fend;

    logic [nv21rgb_pkg::BYTE_W-1:0]         y_off;
    logic signed [nv21rgb_pkg::BYTE_W:0]    dv;
    logic signed [nv21rgb_pkg::BYTE_W:0]    du;
    logic signed [nv21rgb_pkg::SUM_W-1:0]   y1_s;
    logic signed [nv21rgb_pkg::SUM_W-1:0]   sum_r;
    logic signed [nv21rgb_pkg::SUM_W-1:0]   sum_g;
    logic signed [nv21rgb_pkg::SUM_W-1:0]   sum_b;

    // luma floor of 16, chroma centered on 128
    assign y_off = (ram_rdata < nv21rgb_pkg::Y_MIN) ? '0 : ram_rdata - nv21rgb_pkg::Y_MIN;
    assign dv    = $signed({1'b0, r_rd_meta.v}) - $signed(nv21rgb_pkg::CHROMA_MID);
    assign du    = $signed({1'b0, r_rd_meta.u}) - $signed(nv21rgb_pkg::CHROMA_MID);

    assign y1_s  = $signed(nv21rgb_pkg::SUM_W'(r_mul_y1));
    assign sum_r = y1_s + nv21rgb_pkg::SUM_W'(r_mul_pr);
    assign sum_g = y1_s - nv21rgb_pkg::SUM_W'(r_mul_pgv) - nv21rgb_pkg::SUM_W'(r_mul_pgu);
    assign sum_b = y1_s + nv21rgb_pkg::SUM_W'(r_mul_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_rd_valid  <= job_issue;
            r_mul_valid <= r_rd_valid;
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_meta  <= job_meta;
            r_mul_meta <= r_rd_meta;
            r_mul_y1   <= nv21rgb_pkg::Y1_W'(nv21rgb_pkg::Y1_W'(y_off)
                                             * nv21rgb_pkg::Y1_W'(nv21rgb_pkg::COEF_Y));
            r_mul_pr   <= nv21rgb_pkg::MUL_W'(nv21rgb_pkg::MUL_W'(dv)
                                              * nv21rgb_pkg::MUL_W'(nv21rgb_pkg::COEF_RV));
            r_mul_pgv  <= nv21rgb_pkg::MUL_W'(nv21rgb_pkg::MUL_W'(dv)
                                              * nv21rgb_pkg::MUL_W'(nv21rgb_pkg::COEF_GV));
            r_mul_pgu  <= nv21rgb_pkg::MUL_W'(nv21rgb_pkg::MUL_W'(du)
                                              * nv21rgb_pkg::MUL_W'(nv21rgb_pkg::COEF_GU));
            r_mul_pb   <= nv21rgb_pkg::MUL_W'(nv21rgb_pkg::MUL_W'(du)
                                              * nv21rgb_pkg::MUL_W'(nv21rgb_pkg::COEF_BU));
            r_out_red   <= nv21rgb_pkg::clamp_comp(sum_r);
            r_out_green <= nv21rgb_pkg::clamp_comp(sum_g);
            r_out_blue  <= nv21rgb_pkg::clamp_comp(sum_b);
            r_out_col   <= r_mul_meta.col;
            r_out_row   <= r_mul_meta.row;
            r_out_last  <= r_mul_meta.last;
            r_out_fend  <= r_mul_meta.fend;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_red         = r_out_red;
    assign o_green       = r_out_green;
    assign o_blue        = r_out_blue;
    assign o_out_col     = r_out_col;
    assign o_out_row     = r_out_row;
    assign o_last_of_run = r_out_last;
    assign o_frame_end   = r_out_fend;

`ifndef SYNTHESIS
    // a luma write never lands while a pair still has reads pending
    a_no_write_during_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_job_valid)
        else $error("luma write while pair reads pending");

    // frame end only on the closing pixel of a pair
    a_fend_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid & o_frame_end) |-> o_last_of_run)
        else $error("frame end without last of run");

    // unrotated closing pixel sits at odd column and odd row
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid & o_last_of_run & !r_rotate_mode) |-> (o_out_col[0] & o_out_row[0]))
        else $error("last pixel of pair not bottom-right");

    // no byte is taken while the chroma position is being recomputed
    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_state != nv21rgb_pkg::DIV_IDLE) |-> !(i_valid & !o_stall))
        else $error("byte accepted during position recompute");
`endif

endmodule
